@@ rtl/grdw_pkg.sv @@
// shared constants and control types for the grid ray walker
package grdw_pkg;

  localparam int POS_W      = 18;
  localparam int DIR_W      = 16;
  localparam int DIST_W     = 32;
  localparam int CELL_SHIFT = 14;
  localparam int CODE_W     = 4;
  localparam int GRID_W     = 4;
  localparam int IDX_W      = 8;
  localparam int MAP_DEPTH  = 256;
  localparam int STEP_W     = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int LINE_W     = 19;
  localparam int DIFF_W     = 20;
  localparam int PROD_W     = 36;
  localparam int DIV_W      = 34;
  localparam int DEN_W      = 16;
  localparam int STATUS_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WALL_CODE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEPS = 4'd1;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_CAST  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_WALL  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EXIT  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_LIMIT = 2'd2;

  localparam logic [1:0] DIV_RECIP_X = 2'd0;
  localparam logic [1:0] DIV_RECIP_Y = 2'd1;
  localparam logic [1:0] DIV_CROSS   = 2'd2;

  localparam logic [DIV_W-1:0]  RECIP_NUM = 34'h0_4000_0000;
  localparam logic [POS_W-1:0]  POS_MAX   = 18'h3FFFF;
  localparam logic [DIST_W-1:0] DIST_MAX  = 32'hFFFF_FFFF;
  localparam logic [CELL_SHIFT:0] CELL_UNITS = 15'd16384;

  typedef struct packed {
    logic       load;
    logic       map_write;
    logic       div_start;
    logic [1:0] div_sel;
    logic       store_ddx;
    logic       store_ddy;
    logic       first_side;
    logic       step;
    logic       finish;
    logic       cross_mul;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic walk_end;
    logic den_zero;
  } dp_stat_t;

endpackage

@@ rtl/grdw_in_if.sv @@
// input item channel
interface grdw_in_if;
  logic                               valid;
  logic                               ready;
  logic                               action;
  logic [grdw_pkg::IDX_W-1:0]         cell_index;
  logic [grdw_pkg::CODE_W-1:0]        cell_value;
  logic [grdw_pkg::POS_W-1:0]         start_x;
  logic [grdw_pkg::POS_W-1:0]         start_y;
  logic signed [grdw_pkg::DIR_W-1:0]  dir_x;
  logic signed [grdw_pkg::DIR_W-1:0]  dir_y;
  modport source(output valid, action, cell_index, cell_value, start_x, start_y, dir_x, dir_y,
                 input ready);
  modport sink(input valid, action, cell_index, cell_value, start_x, start_y, dir_x, dir_y,
               output ready);
endinterface

@@ rtl/grdw_out_if.sv @@
// result item channel
interface grdw_out_if;
  logic                           valid;
  logic                           ready;
  logic [grdw_pkg::POS_W-1:0]     hit_x;
  logic [grdw_pkg::POS_W-1:0]     hit_y;
  logic [grdw_pkg::GRID_W-1:0]    cell_col;
  logic [grdw_pkg::GRID_W-1:0]    cell_row;
  logic                           hit_side;
  logic [grdw_pkg::CODE_W-1:0]    hit_code;
  logic [grdw_pkg::STATUS_W-1:0]  status;
  modport source(output valid, hit_x, hit_y, cell_col, cell_row, hit_side, hit_code, status,
                 input ready);
  modport sink(input valid, hit_x, hit_y, cell_col, cell_row, hit_side, hit_code, status,
               output ready);
endinterface

@@ rtl/grdw_cfg_if.sv @@
// configuration write channel
interface grdw_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [grdw_pkg::CFG_IDX_W-1:0]   index;
  logic [grdw_pkg::CFG_DATA_W-1:0]  data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/grid_ray_dda_walker.sv @@
// grid ray walker top level: sequencer, datapath and channel ports
// write item: written to the map when taken, no result; cast item: two reciprocals and
// a crossing on the shared bit-serial divider with the grid steps between them, the
// crossing division skipped when its divisor is zero; no new item is taken until the
// result is loaded into the output register, and an untaken result holds the walker
// sync active-low reset: map cleared via per-cell valid bits, walk state, wall_code 1, max_steps 32
module grid_ray_dda_walker (
  input  logic             clk,
  input  logic             rst_n,
  grdw_in_if.sink          in_ch,
  grdw_out_if.source       out_ch,
  grdw_cfg_if.sink         cfg_ch
);
  grdw_pkg::dp_cmd_t  cmd;
  grdw_pkg::dp_stat_t stat;

  // config writes are always taken
  assign cfg_ch.ready = 1'b1;

  // sequencer: one item at a time, result held in the output register
  grdw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath: map, dda state, divider and result payload
  grdw_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_cell_index (in_ch.cell_index),
    .in_cell_value (in_ch.cell_value),
    .in_start_x    (in_ch.start_x),
    .in_start_y    (in_ch.start_y),
    .in_dir_x      (in_ch.dir_x),
    .in_dir_y      (in_ch.dir_y),
    .cfg_we        (cfg_ch.valid),
    .cfg_index     (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .out_hit_x     (out_ch.hit_x),
    .out_hit_y     (out_ch.hit_y),
    .out_cell_col  (out_ch.cell_col),
    .out_cell_row  (out_ch.cell_row),
    .out_hit_side  (out_ch.hit_side),
    .out_hit_code  (out_ch.hit_code),
    .out_status    (out_ch.status)
  );
endmodule

@@ rtl/grdw_div.sv @@
// iterative restoring divider, one quotient bit per cycle
module grdw_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [grdw_pkg::DIV_W-1:0]     dividend,
  input  logic [grdw_pkg::DEN_W-1:0]     divisor,
  output logic                           done,
  output logic [grdw_pkg::DIV_W-1:0]     quotient
);
  localparam int CNT_W = $clog2(grdw_pkg::DIV_W);

  logic [grdw_pkg::DEN_W-1:0] den_r;
  logic [grdw_pkg::DEN_W-1:0] rem_r, rem_nxt;
  logic [grdw_pkg::DIV_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]           cnt_r;
  logic                       busy_r, done_r;
  logic [grdw_pkg::DEN_W:0]   shifted, trial;

  always_comb begin
    shifted = {rem_r, quo_r[grdw_pkg::DIV_W-1]};
    trial   = shifted - {1'b0, den_r};
    if (trial[grdw_pkg::DEN_W]) begin
      rem_nxt = shifted[grdw_pkg::DEN_W-1:0];
      quo_nxt = {quo_r[grdw_pkg::DIV_W-2:0], 1'b0};
    end else begin
      rem_nxt = trial[grdw_pkg::DEN_W-1:0];
      quo_nxt = {quo_r[grdw_pkg::DIV_W-2:0], 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(grdw_pkg::DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= divisor;
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

@@ rtl/grdw_dp.sv @@
// walker datapath: map, side distances, walk position, crossing and result registers
module grdw_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  grdw_pkg::dp_cmd_t                   cmd,
  output grdw_pkg::dp_stat_t                  stat,
  input  logic [grdw_pkg::IDX_W-1:0]          in_cell_index,
  input  logic [grdw_pkg::CODE_W-1:0]         in_cell_value,
  input  logic [grdw_pkg::POS_W-1:0]          in_start_x,
  input  logic [grdw_pkg::POS_W-1:0]          in_start_y,
  input  logic signed [grdw_pkg::DIR_W-1:0]   in_dir_x,
  input  logic signed [grdw_pkg::DIR_W-1:0]   in_dir_y,
  input  logic                                cfg_we,
  input  logic [grdw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [grdw_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [grdw_pkg::POS_W-1:0]          out_hit_x,
  output logic [grdw_pkg::POS_W-1:0]          out_hit_y,
  output logic [grdw_pkg::GRID_W-1:0]         out_cell_col,
  output logic [grdw_pkg::GRID_W-1:0]         out_cell_row,
  output logic                                out_hit_side,
  output logic [grdw_pkg::CODE_W-1:0]         out_hit_code,
  output logic [grdw_pkg::STATUS_W-1:0]       out_status
);
  localparam int CS = grdw_pkg::CELL_SHIFT;
  localparam int MW = CS + 1 + grdw_pkg::DIST_W;
  localparam int GRID_W5 = grdw_pkg::GRID_W + 1;

  logic [grdw_pkg::CODE_W-1:0]       map_mem [grdw_pkg::MAP_DEPTH];
  logic [grdw_pkg::MAP_DEPTH-1:0]    map_vld_r;
  logic [grdw_pkg::CODE_W-1:0]       rd_code_r;
  logic                              rd_vld_r;

  logic [grdw_pkg::CODE_W-1:0]       wall_code_r;
  logic [grdw_pkg::STEP_W-1:0]       max_steps_r;

  logic [grdw_pkg::POS_W-1:0]        sx_r, sy_r;
  logic signed [grdw_pkg::DIR_W-1:0] dx_r, dy_r;
  logic [grdw_pkg::DIST_W-1:0]       ddx_r, ddy_r, sdx_r, sdy_r;
  logic [GRID_W5-1:0]                col_r, row_r, col_nxt, row_nxt;
  logic [grdw_pkg::STEP_W-1:0]       step_r;
  logic                              side_r;
  logic [grdw_pkg::LINE_W-1:0]       line_r;
  logic [grdw_pkg::CODE_W-1:0]       code_r;
  logic [grdw_pkg::STATUS_W-1:0]     status_r;
  logic signed [grdw_pkg::PROD_W-1:0] prod_r;

  // divider operands
  logic                              div_done;
  logic [grdw_pkg::DIV_W-1:0]        div_q, div_a;
  logic [grdw_pkg::DEN_W-1:0]        div_b;
  logic signed [grdw_pkg::DIR_W-1:0] den;
  logic [grdw_pkg::DEN_W-1:0]        mag_dx, mag_dy, mag_den;
  logic [grdw_pkg::DIV_W-1:0]        mag_prod;

  // stepping
  logic                              xstep;
  logic [GRID_W5-1:0]                line_cell;
  logic [grdw_pkg::DIST_W:0]         sum_x, sum_y;
  logic [grdw_pkg::IDX_W-1:0]        rd_addr;

  // walk end test
  logic                              out_grid;
  logic [grdw_pkg::CODE_W-1:0]       cur_code;

  // first side distances
  logic [CS:0]                       rem_x, rem_y;
  logic [MW-1:0]                     first_x, first_y;

  // crossing
  logic signed [grdw_pkg::DIFF_W-1:0] diff;
  logic signed [grdw_pkg::DIR_W-1:0]  num;
  logic [grdw_pkg::POS_W-1:0]         s_this, s_other;
  logic                               neg_q;
  logic signed [grdw_pkg::PROD_W:0]   cross_h;
  logic [grdw_pkg::POS_W-1:0]         cross_pos, line_pos;

  function automatic logic [grdw_pkg::GRID_W-1:0] clamp_cell(input logic [GRID_W5-1:0] c);
    logic [grdw_pkg::GRID_W-1:0] r;
    if (!c[grdw_pkg::GRID_W]) r = c[grdw_pkg::GRID_W-1:0];
    else if (c[grdw_pkg::GRID_W-1:0] == '0) r = '1;
    else r = '0;
    return r;
  endfunction

  assign mag_dx  = dx_r[grdw_pkg::DIR_W-1] ? grdw_pkg::DEN_W'(-dx_r) : grdw_pkg::DEN_W'(dx_r);
  assign mag_dy  = dy_r[grdw_pkg::DIR_W-1] ? grdw_pkg::DEN_W'(-dy_r) : grdw_pkg::DEN_W'(dy_r);
  assign den     = side_r ? dy_r : dx_r;
  assign num     = side_r ? dx_r : dy_r;
  assign mag_den = side_r ? mag_dy : mag_dx;
  assign mag_prod = prod_r[grdw_pkg::PROD_W-1] ? grdw_pkg::DIV_W'(-prod_r)
                                               : grdw_pkg::DIV_W'(prod_r);

  always_comb begin
    case (cmd.div_sel)
      grdw_pkg::DIV_RECIP_X: begin
        div_a = grdw_pkg::RECIP_NUM;
        div_b = mag_dx;
      end
      grdw_pkg::DIV_RECIP_Y: begin
        div_a = grdw_pkg::RECIP_NUM;
        div_b = mag_dy;
      end
      default: begin
        div_a = mag_prod;
        div_b = mag_den;
      end
    endcase
  end

  grdw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // one dda step
  always_comb begin
    xstep   = sdx_r < sdy_r;
    sum_x   = {1'b0, sdx_r} + {1'b0, ddx_r};
    sum_y   = {1'b0, sdy_r} + {1'b0, ddy_r};
    col_nxt = col_r;
    row_nxt = row_r;
    if (xstep) begin
      line_cell = dx_r[grdw_pkg::DIR_W-1] ? col_r : col_r + 1'b1;
      col_nxt   = dx_r[grdw_pkg::DIR_W-1] ? col_r - 1'b1 : col_r + 1'b1;
    end else begin
      line_cell = dy_r[grdw_pkg::DIR_W-1] ? row_r : row_r + 1'b1;
      row_nxt   = dy_r[grdw_pkg::DIR_W-1] ? row_r - 1'b1 : row_r + 1'b1;
    end
    rd_addr = {row_nxt[grdw_pkg::GRID_W-1:0], col_nxt[grdw_pkg::GRID_W-1:0]};
  end

  assign out_grid = col_r[grdw_pkg::GRID_W] | row_r[grdw_pkg::GRID_W];
  assign cur_code = rd_vld_r ? rd_code_r : '0;

  assign stat.div_done = div_done;
  assign stat.den_zero = (den == '0);
  assign stat.walk_end = out_grid || (cur_code == wall_code_r) || (step_r >= max_steps_r);

  // first side distance, distance to the next grid line times delta over one cell
  always_comb begin
    rem_x   = dx_r[grdw_pkg::DIR_W-1] ? {1'b0, sx_r[CS-1:0]}
                                      : grdw_pkg::CELL_UNITS - {1'b0, sx_r[CS-1:0]};
    rem_y   = dy_r[grdw_pkg::DIR_W-1] ? {1'b0, sy_r[CS-1:0]}
                                      : grdw_pkg::CELL_UNITS - {1'b0, sy_r[CS-1:0]};
    first_x = MW'(rem_x) * MW'(ddx_r);
    first_y = MW'(rem_y) * MW'(ddy_r);
  end

  // crossing on the other axis
  always_comb begin
    s_this    = side_r ? sy_r : sx_r;
    s_other   = side_r ? sx_r : sy_r;
    diff      = $signed({1'b0, line_r}) - $signed({2'b00, s_this});
    neg_q     = prod_r[grdw_pkg::PROD_W-1] ^ den[grdw_pkg::DIR_W-1];
    if (den == '0)
      cross_h = $signed({19'd0, s_other});
    else if (neg_q)
      cross_h = $signed({19'd0, s_other}) - $signed({3'b000, div_q});
    else
      cross_h = $signed({19'd0, s_other}) + $signed({3'b000, div_q});
    if (cross_h[grdw_pkg::PROD_W])
      cross_pos = '0;
    else if (cross_h > $signed({19'd0, grdw_pkg::POS_MAX}))
      cross_pos = grdw_pkg::POS_MAX;
    else
      cross_pos = cross_h[grdw_pkg::POS_W-1:0];
    line_pos = line_r[grdw_pkg::LINE_W-1] ? grdw_pkg::POS_MAX : line_r[grdw_pkg::POS_W-1:0];
  end

  // map store, cleared on reset through its valid bits
  always_ff @(posedge clk) begin
    if (cmd.map_write)
      map_mem[in_cell_index] <= in_cell_value;
    rd_code_r <= map_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_vld_r   <= '0;
      rd_vld_r    <= 1'b0;
      wall_code_r <= 4'd1;
      max_steps_r <= 7'd32;
    end else begin
      if (cmd.map_write)
        map_vld_r[in_cell_index] <= 1'b1;
      rd_vld_r <= map_vld_r[rd_addr];
      if (cfg_we) begin
        unique case (cfg_index)
          grdw_pkg::REG_WALL_CODE: wall_code_r <= cfg_data[grdw_pkg::CODE_W-1:0];
          grdw_pkg::REG_MAX_STEPS: max_steps_r <= cfg_data[grdw_pkg::STEP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sdx_r  <= '0;
      sdy_r  <= '0;
      col_r  <= '0;
      row_r  <= '0;
      step_r <= '0;
    end else begin
      if (cmd.load) begin
        col_r  <= {1'b0, in_start_x[grdw_pkg::POS_W-1 -: grdw_pkg::GRID_W]};
        row_r  <= {1'b0, in_start_y[grdw_pkg::POS_W-1 -: grdw_pkg::GRID_W]};
        step_r <= '0;
      end
      if (cmd.first_side) begin
        sdx_r <= first_x[CS +: grdw_pkg::DIST_W];
        sdy_r <= first_y[CS +: grdw_pkg::DIST_W];
      end
      if (cmd.step) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        step_r <= step_r + 1'b1;
        if (xstep)
          sdx_r <= sum_x[grdw_pkg::DIST_W] ? grdw_pkg::DIST_MAX : sum_x[grdw_pkg::DIST_W-1:0];
        else
          sdy_r <= sum_y[grdw_pkg::DIST_W] ? grdw_pkg::DIST_MAX : sum_y[grdw_pkg::DIST_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx_r <= in_start_x;
      sy_r <= in_start_y;
      dx_r <= in_dir_x;
      dy_r <= in_dir_y;
    end
    if (cmd.store_ddx)
      ddx_r <= (dx_r == '0) ? grdw_pkg::DIST_MAX : div_q[grdw_pkg::DIST_W-1:0];
    if (cmd.store_ddy)
      ddy_r <= (dy_r == '0) ? grdw_pkg::DIST_MAX : div_q[grdw_pkg::DIST_W-1:0];
    if (cmd.step) begin
      side_r <= ~xstep;
      line_r <= {line_cell, {CS{1'b0}}};
    end
    if (cmd.finish) begin
      if (out_grid) begin
        code_r   <= '0;
        status_r <= grdw_pkg::STATUS_EXIT;
      end else if (cur_code == wall_code_r) begin
        code_r   <= cur_code;
        status_r <= grdw_pkg::STATUS_WALL;
      end else begin
        code_r   <= cur_code;
        status_r <= grdw_pkg::STATUS_LIMIT;
      end
    end
    if (cmd.cross_mul)
      prod_r <= grdw_pkg::PROD_W'(diff) * grdw_pkg::PROD_W'(num);
    if (cmd.out_load) begin
      out_hit_x    <= side_r ? cross_pos : line_pos;
      out_hit_y    <= side_r ? line_pos : cross_pos;
      out_cell_col <= clamp_cell(col_r);
      out_cell_row <= clamp_cell(row_r);
      out_hit_side <= side_r;
      out_hit_code <= code_r;
      out_status   <= status_r;
    end
  end
endmodule

@@ rtl/grdw_ctrl.sv @@
// walker sequencer
module grdw_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_action,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output grdw_pkg::dp_cmd_t  cmd,
  input  grdw_pkg::dp_stat_t stat
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RX    = 4'd1;
  localparam logic [3:0] S_RXW   = 4'd2;
  localparam logic [3:0] S_RY    = 4'd3;
  localparam logic [3:0] S_RYW   = 4'd4;
  localparam logic [3:0] S_FIRST = 4'd5;
  localparam logic [3:0] S_STEP  = 4'd6;
  localparam logic [3:0] S_CHECK = 4'd7;
  localparam logic [3:0] S_XMUL  = 4'd8;
  localparam logic [3:0] S_XDIV  = 4'd9;
  localparam logic [3:0] S_XWAIT = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.div_sel   = grdw_pkg::DIV_CROSS;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_action == grdw_pkg::ACT_CAST) begin
            cmd.load  = 1'b1;
            state_nxt = S_RX;
          end else begin
            cmd.map_write = 1'b1;
          end
        end
      end
      S_RX: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = grdw_pkg::DIV_RECIP_X;
        state_nxt     = S_RXW;
      end
      S_RXW: begin
        if (stat.div_done) begin
          cmd.store_ddx = 1'b1;
          state_nxt     = S_RY;
        end
      end
      S_RY: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = grdw_pkg::DIV_RECIP_Y;
        state_nxt     = S_RYW;
      end
      S_RYW: begin
        if (stat.div_done) begin
          cmd.store_ddy = 1'b1;
          state_nxt     = S_FIRST;
        end
      end
      S_FIRST: begin
        cmd.first_side = 1'b1;
        state_nxt      = S_STEP;
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.walk_end) begin
          cmd.finish = 1'b1;
          state_nxt  = S_XMUL;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_XMUL: begin
        cmd.cross_mul = 1'b1;
        state_nxt     = S_XDIV;
      end
      S_XDIV: begin
        if (stat.den_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_XWAIT;
        end
      end
      S_XWAIT: begin
        if (stat.div_done)
          state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

@@ sim/tb_grdw_if.sv @@
// input gap setting: largest random gap before each input item, set by the tests
interface tb_grdw_pace_if (input logic clk);
  int unsigned max_gap;
  modport ctrl(output max_gap);
  modport user(input max_gap, input clk);
endinterface

@@ sim/tb_grid_ray_dda_walker.sv @@
// self-checking testbench for the grid ray walker: map writes, casts, register changes
module tb_grid_ray_dda_walker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS_PER_SIDE = 16;
  localparam longint UNITS = 16384;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [grdw_pkg::POS_W-1:0]    hx;
    logic [grdw_pkg::POS_W-1:0]    hy;
    logic [grdw_pkg::GRID_W-1:0]   col;
    logic [grdw_pkg::GRID_W-1:0]   row;
    logic                          side;
    logic [grdw_pkg::CODE_W-1:0]   code;
    logic [grdw_pkg::STATUS_W-1:0] stat;
  } ray_hit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  grdw_in_if  in_ch();
  grdw_out_if out_ch();
  grdw_cfg_if cfg_ch();
  tb_grdw_pace_if pace(clk);

  grid_ray_dda_walker DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                           .cfg_ch(cfg_ch));

  // predictor state: map copy and registers
  logic [grdw_pkg::CODE_W-1:0] map_copy [grdw_pkg::MAP_DEPTH];
  logic [grdw_pkg::CODE_W-1:0] wall_reg;
  logic [6:0]                  steps_reg;

  ray_hit_t hits_due[$];
  int       errors = 0;
  int       idle_cycles = 0;
  bit       out_stall_on = 1'b1;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  function automatic longint unsigned recip_of(input longint d);
    longint unsigned m, q;
    m = (d < 0) ? -d : d;
    if (m == 0) return 64'hFFFF_FFFF;
    q = (64'd1 << 30) / m;
    return (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
  endfunction

  function automatic longint unsigned capped(input longint unsigned v);
    return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
  endfunction

  function automatic longint pos_clamp(input longint v);
    longint lim;
    lim = CELLS_PER_SIDE * UNITS;
    if (lim > 262143) lim = 262143;
    if (v < 0) return 0;
    return (v > lim) ? lim : v;
  endfunction

  function automatic logic [3:0] cell_clamp(input int c);
    if (c < 0) c = 0;
    if (c >= CELLS_PER_SIDE) c = CELLS_PER_SIDE - 1;
    return c[3:0];
  endfunction

  // crossing on the other axis, division truncated toward zero
  function automatic longint cross_at(input longint so, input longint ln, input longint st,
                                      input longint num, input longint den);
    longint p;
    if (den == 0) return so;
    p = (ln - st) * num;
    return so + p / den;
  endfunction

  // walks the ray through the map copy and returns what the block should report
  function automatic ray_hit_t walk_ray(input logic [17:0] sx0, input logic [17:0] sy0,
                                        input logic signed [15:0] dx0,
                                        input logic signed [15:0] dy0);
    ray_hit_t r;
    longint sx, sy, hx, hy, dx, dy, f;
    longint unsigned ddx, ddy, sdx, sdy;
    int col, row, cnt, lim;
    logic [3:0] code;
    logic side;
    logic [1:0] st;
    sx = sx0; sy = sy0; dx = dx0; dy = dy0;
    hx = sx; hy = sy;
    col = int'(sx / UNITS); row = int'(sy / UNITS);
    ddx = recip_of(dx); ddy = recip_of(dy);
    side = 1'b0; code = '0; cnt = 0;
    lim = (steps_reg == 0) ? 1 : steps_reg;
    if (col >= CELLS_PER_SIDE || row >= CELLS_PER_SIDE) begin
      st = grdw_pkg::STATUS_EXIT;
    end else begin
      f = sx - col * UNITS;
      sdx = capped(longint'(dx < 0 ? f : UNITS - f) * ddx / UNITS);
      f = sy - row * UNITS;
      sdy = capped(longint'(dy < 0 ? f : UNITS - f) * ddy / UNITS);
      forever begin
        if (sdx < sdy) begin
          hx = (dx < 0 ? col : col + 1) * UNITS;
          hy = cross_at(sy, hx, sx, dy, dx);
          sdx = capped(sdx + ddx);
          col += (dx < 0) ? -1 : 1;
          side = 1'b0;
        end else begin
          hy = (dy < 0 ? row : row + 1) * UNITS;
          hx = cross_at(sx, hy, sy, dx, dy);
          sdy = capped(sdy + ddy);
          row += (dy < 0) ? -1 : 1;
          side = 1'b1;
        end
        cnt++;
        if (col < 0 || col >= CELLS_PER_SIDE || row < 0 || row >= CELLS_PER_SIDE) begin
          code = '0; st = grdw_pkg::STATUS_EXIT; break;
        end
        code = map_copy[row * CELLS_PER_SIDE + col];
        if (code == wall_reg) begin
          st = grdw_pkg::STATUS_WALL; break;
        end
        if (cnt >= lim) begin
          st = grdw_pkg::STATUS_LIMIT; break;
        end
      end
    end
    r.hx = grdw_pkg::POS_W'(pos_clamp(hx)); r.hy = grdw_pkg::POS_W'(pos_clamp(hy));
    r.col = cell_clamp(col); r.row = cell_clamp(row);
    r.side = side; r.code = code; r.stat = st;
    return r;
  endfunction

  // sends one item after a random gap, then updates the predictor;
  // valid stays up until the next item or a drain changes it
  task automatic send_item(input logic act, input logic [7:0] idx, input logic [3:0] val,
                           input logic [17:0] sx, input logic [17:0] sy,
                           input logic signed [15:0] dx, input logic signed [15:0] dy,
                           input bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(pace.max_gap, 0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act; in_ch.cell_index <= idx; in_ch.cell_value <= val;
    in_ch.start_x <= sx; in_ch.start_y <= sy; in_ch.dir_x <= dx; in_ch.dir_y <= dy;
    do @(posedge clk); while (!in_ch.ready);
    if (act == grdw_pkg::ACT_WRITE) map_copy[idx] = val;
    else hits_due.push_back(walk_ray(sx, sy, dx, dy));
    @(negedge clk);
  endtask

  task automatic write_cell(input int idx, input int val);
    send_item(grdw_pkg::ACT_WRITE, idx[7:0], val[3:0], 18'($urandom), 18'($urandom),
              16'($urandom), 16'($urandom));
  endtask

  task automatic cast_ray(input int sx, input int sy, input int dx, input int dy);
    send_item(grdw_pkg::ACT_CAST, 8'($urandom), 4'($urandom), sx[17:0], sy[17:0],
              dx[15:0], dy[15:0]);
  endtask

  // stops the input and waits until every expected result is back, then lets the clock run on
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (hits_due.size() != 0) @(negedge clk);
    repeat (250) @(negedge clk);
  endtask

  task automatic write_reg(input logic [grdw_pkg::CFG_IDX_W-1:0] idx, input int val);
    drain();
    cfg_ch.valid <= 1'b1; cfg_ch.index <= idx; cfg_ch.data <= val[7:0];
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == grdw_pkg::REG_WALL_CODE) wall_reg = val[3:0];
    else if (idx == grdw_pkg::REG_MAX_STEPS) steps_reg = val[6:0];
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly a unit direction from a random angle, with axis-aligned, diagonal and raw random picks
  task automatic random_dir(output int dx, output int dy);
    real a;
    case ($urandom_range(9))
      0: begin dx = 16384; dy = 0; end
      1: begin dx = 0; dy = -16384; end
      2: begin dx = -11585; dy = 11585; end
      3: begin dx = $urandom_range(65535) - 32768; dy = $urandom_range(65535) - 32768; end
      default: begin
        a = $urandom_range(62831) / 10000.0;
        dx = $rtoi(16384.0 * $cos(a)); dy = $rtoi(16384.0 * $sin(a));
      end
    endcase
  endtask

  task automatic random_map(input int walls);
    for (int i = 0; i < walls; i++) begin
      write_cell($urandom_range(255), ($urandom_range(2) == 0) ? $urandom_range(15) : wall_reg);
    end
  endtask

  // extremes: corners, zero direction components, starts at the grid edge, full-width values
  task automatic test_directed();
    pace.max_gap = 0;
    cast_ray(32 * 256, 32 * 256, 16384, 0);
    cast_ray(32 * 256, 32 * 256, 0, 16384);
    cast_ray(0, 0, -16384, -16384);
    cast_ray(262143, 262143, 16384, 16384);
    cast_ray(262143, 1000, -16384, 0);
    cast_ray(100, 262143, 0, -16384);
    cast_ray(8192, 8192, 0, 0);
    cast_ray(8192, 8192, 11585, 11585);
    cast_ray(16384, 16384, -32768, 32767);
    cast_ray(245759, 245759, 16384, 1);
    write_cell(0, 15);
    write_cell(255, 1);
    write_cell(17, 1);
    write_cell(18, 1);
    cast_ray(8192, 8192, 16384, 16384);
    cast_ray(8192, 24576, 16384, 0);
    cast_ray(245760, 245760, 16384, 16384);
    cast_ray(40000, 40000, -16384, -16384);
  endtask

  task automatic test_config_sweep();
    int dx, dy;
    int codes[4] = '{0, 15, 3, 1};
    int limits[4] = '{1, 64, 0, 127};
    for (int p = 0; p < 4; p++) begin
      write_reg(grdw_pkg::REG_WALL_CODE, codes[p]);
      write_reg(grdw_pkg::REG_MAX_STEPS, limits[p]);
      pace.max_gap = 5;
      random_map(8);
      for (int i = 0; i < 15; i++) begin
        random_dir(dx, dy);
        cast_ray($urandom_range(262143), $urandom_range(262143), dx, dy);
      end
    end
  endtask

  // bulk random: mostly casts from inside the grid, across several register settings
  task automatic test_random();
    int dx, dy;
    for (int p = 0; p < 6; p++) begin
      write_reg(grdw_pkg::REG_WALL_CODE, $urandom_range(15));
      write_reg(grdw_pkg::REG_MAX_STEPS, (p == 0) ? 64 : $urandom_range(64, 1));
      out_stall_on = (p != 2);
      pace.max_gap = (p == 3) ? 0 : 5;
      for (int i = 0; i < 224; i++) begin
        if ($urandom_range(3) == 0) begin
          write_cell($urandom_range(255), ($urandom_range(1)) ? wall_reg : $urandom_range(15));
        end else begin
          random_dir(dx, dy);
          if ($urandom_range(9) == 0)
            cast_ray($urandom_range(262143), $urandom_range(262143), dx, dy);
          else
            cast_ray($urandom_range(262143 - 16384 - 1), $urandom_range(262143 - 16384 - 1),
                     dx, dy);
        end
      end
    end
    out_stall_on = 1'b1;
  endtask

  // result side: random stalls while out_stall_on is set, compare against the oldest prediction
  initial begin
    ray_hit_t w;
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = out_stall_on ? $urandom_range(5) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (hits_due.size() == 0) begin
        report_mismatch("result with nothing expected", 0, 0);
      end else begin
        w = hits_due.pop_front();
        if (out_ch.hit_x !== w.hx) report_mismatch("hit_x", out_ch.hit_x, w.hx);
        if (out_ch.hit_y !== w.hy) report_mismatch("hit_y", out_ch.hit_y, w.hy);
        if (out_ch.cell_col !== w.col) report_mismatch("cell_col", out_ch.cell_col, w.col);
        if (out_ch.cell_row !== w.row) report_mismatch("cell_row", out_ch.cell_row, w.row);
        if (out_ch.hit_side !== w.side) report_mismatch("hit_side", out_ch.hit_side, w.side);
        if (out_ch.hit_code !== w.code) report_mismatch("hit_code", out_ch.hit_code, w.code);
        if (out_ch.status !== w.stat) report_mismatch("status", out_ch.status, w.stat);
      end
    end
  end

  // watchdog: cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_grid_ray_dda_walker failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0; in_ch.action = grdw_pkg::ACT_WRITE; in_ch.cell_index = '0;
    in_ch.cell_value = '0; in_ch.start_x = '0; in_ch.start_y = '0;
    in_ch.dir_x = '0; in_ch.dir_y = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = grdw_pkg::REG_WALL_CODE; cfg_ch.data = '0;
    pace.max_gap = 5;
    for (int i = 0; i < grdw_pkg::MAP_DEPTH; i++) map_copy[i] = '0;
    wall_reg = 4'd1;
    steps_reg = 7'd32;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_config_sweep();
    test_random();
    drain();
    if (errors == 0) begin
      $display("tb_grid_ray_dda_walker passed");
    end else begin
      $display("tb_grid_ray_dda_walker failed");
    end
    $finish;
  end

endmodule
